/* src/sdle_pkg.sv */
// sdle_pkg: shared types, command and status codes for the sorted deque list engine
// no dependencies; imported by sdle_cell and sorted_deque_list_engine_core
package sdle_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;
    localparam int ST_W  = 2;
    localparam int EC_W  = 5;

    typedef logic signed [31:0] t_word;
    typedef logic [CNT_W-1:0]   t_count;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ORD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic  push_front;
        logic  push_back;
        logic  ord_insert;
        logic  pop_front;
        logic  remove;
        t_word value;
    } t_bcast;

    typedef struct packed {
        logic occupied;
        logic tail;
    } t_cell_pos;

endpackage

/* src/sorted_deque_list_engine_core.sv */
// sorted_deque_list_engine_core: top level, command decode, row of list cells and result register
// depends on sdle_pkg and sdle_cell
//
// Bounded list of up to DEPTH (16) signed 32-bit values held in a row of cells, front at
// cell 0. For every command all cells compare against the broadcast value at once and
// shift by at most one place, so a new command is accepted in every cycle while the result
// register is free or being emptied. The result appears in the cycle after acceptance and is
// held until taken. The cycle time is set by the first-match flags rippling through the row
// of cells (one gate per cell). No clearing pass is needed after reset.
module sorted_deque_list_engine_core
    import sdle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_command,
    input  t_word            i_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ST_W-1:0]  o_status,
    output t_word            o_removed_value,
    output logic [EC_W-1:0]  o_element_count
);

    logic            r_out_valid;
    logic [ST_W-1:0] r_status;
    t_word           r_removed;
    logic [EC_W-1:0] r_ec;
    t_count          r_count;
    t_count          n_count;
    logic [ST_W-1:0] n_status;
    t_word           n_removed;

    logic   in_acc;
    logic   full;
    logic   empty;
    t_bcast bc;
    t_word  vals [DEPTH];
    logic   all_lt [DEPTH+1];
    logic   found [DEPTH+1];
    logic   hit [DEPTH];
    t_word  hit_val;
    t_word  last_val;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign in_acc     = i_in_valid & o_in_ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        bc.push_front = in_acc && !full && (i_command == CMD_PUSH_FRONT);
        bc.push_back  = in_acc && !full && (i_command == CMD_PUSH_BACK);
        bc.ord_insert = in_acc && !full && (i_command == CMD_ORD_INSERT);
        bc.pop_front  = in_acc && !empty && (i_command == CMD_POP_FRONT);
        bc.remove     = in_acc && (i_command == CMD_REMOVE);
        bc.value      = i_value;
    end

    assign all_lt[0] = 1'b1;
    assign found[0]  = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_pos pos;
        t_word     left;
        t_word     right;

        assign pos.occupied = (CNT_W'(i) < r_count);
        assign pos.tail     = (CNT_W'(i) == r_count);

        if (i == 0) begin : g_first
            assign left = i_value;
        end else begin : g_mid_l
            assign left = vals[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right = vals[i];
        end else begin : g_mid_r
            assign right = vals[i+1];
        end

        sdle_cell u_cell (
            .i_clk    (i_clk),
            .i_bc     (bc),
            .i_pos    (pos),
            .i_left   (left),
            .i_right  (right),
            .i_all_lt (all_lt[i]),
            .i_found  (found[i]),
            .o_all_lt (all_lt[i+1]),
            .o_found  (found[i+1]),
            .o_hit    (hit[i]),
            .o_val    (vals[i])
        );
    end

    always_comb begin
        hit_val  = '0;
        last_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit[i]) begin
                hit_val = hit_val | vals[i];
            end
            if (CNT_W'(i + 1) == r_count) begin
                last_val = last_val | vals[i];
            end
        end
    end

    always_comb begin
        n_status  = ST_OK;
        n_removed = '0;
        n_count   = r_count;
        unique case (i_command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_ORD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    n_removed = (i_command == CMD_POP_FRONT) ? vals[0] : last_val;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (found[DEPTH]) begin
                    n_count   = r_count - 1'b1;
                    n_removed = hit_val;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_ec      <= EC_W'(n_count);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_element_count = r_ec;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !full && (i_command == CMD_PUSH_FRONT || i_command == CMD_PUSH_BACK
            || i_command == CMD_ORD_INSERT)
        |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the list");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_FULL) |-> r_ec == EC_W'(DEPTH))
        else $error("full status with short list");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_EMPTY) |-> (r_ec == '0) && (r_removed == '0))
        else $error("empty status with elements or a removed value");

    a_ec_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_ec == EC_W'(r_count))
        else $error("reported count differs from held count");
`endif

endmodule

/* src/sdle_cell.sv */
// sdle_cell: one list position, compares against the broadcast value and shifts
// to or from its neighbours; depends on sdle_pkg
module sdle_cell
    import sdle_pkg::*;
(
    input  logic      i_clk,
    input  t_bcast    i_bc,
    input  t_cell_pos i_pos,
    input  t_word     i_left,
    input  t_word     i_right,
    input  logic      i_all_lt,
    input  logic      i_found,
    output logic      o_all_lt,
    output logic      o_found,
    output logic      o_hit,
    output t_word     o_val
);

    t_word r_val;
    t_word n_val;
    logic  lt;
    logic  eq;

    assign lt       = i_pos.occupied && (r_val < i_bc.value);
    assign eq       = i_pos.occupied && (r_val == i_bc.value);
    assign o_all_lt = i_all_lt & lt;
    assign o_found  = i_found | eq;
    assign o_hit    = eq & ~i_found;
    assign o_val    = r_val;

    always_comb begin
        n_val = r_val;
        priority if (i_bc.push_front) begin
            n_val = i_left;
        end else if (i_bc.push_back) begin
            if (i_pos.tail) begin
                n_val = i_bc.value;
            end
        end else if (i_bc.ord_insert) begin
            if (!i_all_lt) begin
                n_val = i_left;
            end else if (!lt) begin
                n_val = i_bc.value;
            end
        end else if (i_bc.pop_front) begin
            n_val = i_right;
        end else if (i_bc.remove) begin
            if (i_found || eq) begin
                n_val = i_right;
            end
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
